// File: rtl/mrpt_pkg.sv
`default_nettype none

package mrpt_pkg;

   localparam int CAND_W    = 62;  // candidate width
   localparam int S_W       = 6;   // holds the power of two in n-1, at most 61
   localparam int WIT_W     = 4;   // witness index
   localparam int WIT_VAL_W = 6;   // largest witness is 47
   localparam int TABLE_LEN = 15;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_WIT,
      ST_EXP_TEST,
      ST_EXP_MUL,
      ST_EXP_SQR,
      ST_SQ_CHECK,
      ST_SQ_WAIT,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [CAND_W-1:0] mul_a;
      logic [CAND_W-1:0] mul_b;
      logic [CAND_W-1:0] modulus;
   } mul_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

   // first fifteen primes
   function automatic logic [WIT_VAL_W-1:0] witness_value(input logic [WIT_W-1:0] idx);
      logic [WIT_VAL_W-1:0] val;
      case (idx)
         4'd0:    val = 6'd2;
         4'd1:    val = 6'd3;
         4'd2:    val = 6'd5;
         4'd3:    val = 6'd7;
         4'd4:    val = 6'd11;
         4'd5:    val = 6'd13;
         4'd6:    val = 6'd17;
         4'd7:    val = 6'd19;
         4'd8:    val = 6'd23;
         4'd9:    val = 6'd29;
         4'd10:   val = 6'd31;
         4'd11:   val = 6'd37;
         4'd12:   val = 6'd41;
         4'd13:   val = 6'd43;
         default: val = 6'd47;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: rtl/mrpt_req_if.sv
`default_nettype none

interface mrpt_req_if import mrpt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CAND_W-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

`default_nettype wire

// File: rtl/mrpt_rsp_if.sv
`default_nettype none

interface mrpt_rsp_if import mrpt_pkg::*; ();
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

// File: rtl/mrpt_modmul.sv
`default_nettype none

// Bit-serial (a * b) mod n, multiplier bit taken LSB first, one bit per cycle.
// Operands must already be below n. Runs until the multiplier shifts to zero.
module mrpt_modmul import mrpt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  mul_cmd_type    cmd,
   output mul_status_type status,
   output logic [CAND_W-1:0] product
);

   logic              busy_ff, busy_in;
   logic [CAND_W-1:0] x_ff, x_in;
   logic [CAND_W-1:0] y_ff, y_in;
   logic [CAND_W-1:0] acc_ff, acc_in;
   logic [CAND_W-1:0] n_ff, n_in;

   logic [CAND_W:0]   acc_sum;
   logic [CAND_W:0]   x_dbl;
   logic [CAND_W-1:0] acc_red;
   logic [CAND_W-1:0] x_red;
   logic              done;

   assign done = busy_ff && (y_ff == '0);

   // add and double run side by side, each with one conditional subtract
   always_comb begin
      acc_sum = {1'b0, acc_ff} + {1'b0, x_ff};
      x_dbl   = {x_ff, 1'b0};
      acc_red = (acc_sum >= {1'b0, n_ff}) ? CAND_W'(acc_sum - {1'b0, n_ff})
                                          : acc_sum[CAND_W-1:0];
      x_red   = (x_dbl >= {1'b0, n_ff}) ? CAND_W'(x_dbl - {1'b0, n_ff})
                                        : x_dbl[CAND_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      n_in    = n_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         x_in    = cmd.mul_a;
         y_in    = cmd.mul_b;
         acc_in  = '0;
         n_in    = cmd.modulus;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (y_ff[0]) begin
            acc_in = acc_red;
         end
         x_in = x_red;
         y_in = {1'b0, y_ff[CAND_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      n_ff   <= n_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done;
   assign product     = acc_ff;

endmodule

`default_nettype wire

// File: rtl/miller_rabin_prime_test.sv
// Candidates below 3 and even ones go straight to the verdict; otherwise n-1 is split into d * 2^s,
// then, per witness, about (bits of d) * 2 modular products and up to s-1 squarings run, each
// product in the one shared bit-serial multiplier. One item in flight, next taken once its verdict
// sits in the output register. Reset (synchronous, active high) clears state and valids.
`default_nettype none

module miller_rabin_prime_test import mrpt_pkg::*; #(
   parameter int WITNESS_COUNT = 10
) (
   input  logic         clock,
   input  logic         reset,
   mrpt_req_if.sink     req_chan,
   mrpt_rsp_if.source   rsp_chan
);

   // number of witnesses tried, clamped to the table
   localparam logic [WIT_W-1:0] WIT_LIMIT =
      (WITNESS_COUNT > TABLE_LEN) ? WIT_W'(TABLE_LEN) :
      (WITNESS_COUNT < 0)         ? '0 : WIT_W'(WITNESS_COUNT);

   state_type state_ff, state_in;

   logic [CAND_W-1:0] n_ff, n_in;       // candidate
   logic [CAND_W-1:0] d_ff, d_in;       // odd part of n-1
   logic [S_W-1:0]    s_ff, s_in;       // power of two in n-1
   logic [CAND_W-1:0] e_ff, e_in;       // exponent bits still to consume
   logic [CAND_W-1:0] base_ff, base_in; // running square of the witness
   logic [CAND_W-1:0] r_ff, r_in;       // x in the test
   logic [S_W-1:0]    j_ff, j_in;       // squaring count
   logic [WIT_W-1:0]  w_ff, w_in;       // witness index
   logic              verdict_ff, verdict_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_prime_ff, rsp_prime_in;

   mul_cmd_type       mul_cmd;
   mul_status_type    mul_stat;
   logic [CAND_W-1:0] mul_prod;

   logic              req_take;
   logic              rsp_load;
   logic [CAND_W-1:0] n_minus1;
   logic [CAND_W-1:0] wit_val;
   logic              cand_even;
   logic              cand_one;

   // n is odd here, so n-1 just clears bit 0
   assign n_minus1  = {n_ff[CAND_W-1:1], 1'b0};
   assign wit_val   = CAND_W'(witness_value(w_ff));
   assign cand_even = ~req_chan.candidate[0];
   assign cand_one  = (req_chan.candidate == CAND_W'(1));
   assign req_take  = req_chan.valid && req_chan.ready;
   assign rsp_load  = (state_ff == ST_REPORT) && (!rsp_valid_ff || rsp_chan.ready);

   mrpt_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .status  (mul_stat),
      .product (mul_prod)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (cand_even || cand_one) ? ST_REPORT : ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (d_ff[0]) begin
               state_in = ST_WIT;
            end
         end
         ST_WIT: begin
            // out of witnesses, or witness not below n: prime
            if (w_ff == WIT_LIMIT || wit_val >= n_ff) begin
               state_in = ST_REPORT;
            end else begin
               state_in = ST_EXP_TEST;
            end
         end
         ST_EXP_TEST: begin
            if (e_ff == '0) begin
               state_in = (r_ff == CAND_W'(1)) ? ST_WIT : ST_SQ_CHECK;
            end else if (e_ff[0]) begin
               state_in = ST_EXP_MUL;
            end else begin
               state_in = ST_EXP_SQR;
            end
         end
         ST_EXP_MUL: begin
            if (mul_stat.done) begin
               state_in = ST_EXP_SQR;
            end
         end
         ST_EXP_SQR: begin
            if (mul_stat.done) begin
               state_in = ST_EXP_TEST;
            end
         end
         ST_SQ_CHECK: begin
            if (r_ff == n_minus1) begin
               state_in = ST_WIT;
            end else if (S_W'(j_ff + 1'b1) == s_ff) begin
               state_in = ST_REPORT;   // composite
            end else begin
               state_in = ST_SQ_WAIT;
            end
         end
         ST_SQ_WAIT: begin
            if (mul_stat.done) begin
               state_in = ST_SQ_CHECK;
            end
         end
         ST_REPORT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_chan.ready  = 1'b0;
      mul_cmd.start   = 1'b0;
      mul_cmd.mul_a   = base_ff;
      mul_cmd.mul_b   = base_ff;
      mul_cmd.modulus = n_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_EXP_TEST: begin
            if (e_ff != '0) begin
               mul_cmd.start = 1'b1;
               if (e_ff[0]) begin
                  mul_cmd.mul_a = r_ff;
               end
            end
         end
         ST_EXP_MUL: begin
            // chain straight into the base squaring
            mul_cmd.start = mul_stat.done;
            if (mul_stat.done) begin
               mul_cmd.mul_a = base_ff;
               mul_cmd.mul_b = base_ff;
            end
         end
         ST_SQ_CHECK: begin
            mul_cmd.mul_a = r_ff;
            mul_cmd.mul_b = r_ff;
            if (r_ff != n_minus1 && S_W'(j_ff + 1'b1) != s_ff) begin
               mul_cmd.start = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      n_in       = n_ff;
      d_in       = d_ff;
      s_in       = s_ff;
      e_in       = e_ff;
      base_in    = base_ff;
      r_in       = r_ff;
      j_in       = j_ff;
      w_in       = w_ff;
      verdict_in = verdict_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               n_in       = req_chan.candidate;
               d_in       = {req_chan.candidate[CAND_W-1:1], 1'b0};
               s_in       = '0;
               w_in       = '0;
               // only 2 among the trivial cases is prime
               verdict_in = (req_chan.candidate == CAND_W'(2));
            end
         end
         ST_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[CAND_W-1:1]};
               s_in = S_W'(s_ff + 1'b1);
            end
         end
         ST_WIT: begin
            verdict_in = 1'b1;
            r_in       = CAND_W'(1);
            base_in    = wit_val;
            e_in       = d_ff;
         end
         ST_EXP_TEST: begin
            if (e_ff == '0) begin
               j_in = '0;
               if (r_ff == CAND_W'(1)) begin
                  w_in = WIT_W'(w_ff + 1'b1);
               end
            end
         end
         ST_EXP_MUL: begin
            if (mul_stat.done) begin
               r_in = mul_prod;
            end
         end
         ST_EXP_SQR: begin
            if (mul_stat.done) begin
               base_in = mul_prod;
               e_in    = {1'b0, e_ff[CAND_W-1:1]};
            end
         end
         ST_SQ_CHECK: begin
            if (r_ff == n_minus1) begin
               w_in = WIT_W'(w_ff + 1'b1);
            end else if (S_W'(j_ff + 1'b1) == s_ff) begin
               verdict_in = 1'b0;
            end
         end
         ST_SQ_WAIT: begin
            if (mul_stat.done) begin
               r_in = mul_prod;
               j_in = S_W'(j_ff + 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   // output register: holds the verdict while the next item is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_prime_in = rsp_prime_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_prime_in = verdict_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      d_ff         <= d_in;
      s_ff         <= s_in;
      e_ff         <= e_in;
      base_ff      <= base_in;
      r_ff         <= r_in;
      j_ff         <= j_in;
      w_ff         <= w_in;
      verdict_ff   <= verdict_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.is_prime = rsp_prime_ff;

   // ---------------------------------------------------------------- checks
   // splitting n-1 never runs on a zero value
   a_split_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SPLIT |-> d_ff != '0)
      else $error("split of n-1 on zero");

   // squaring loop stays within s steps
   a_sq_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQ_CHECK |-> j_ff < s_ff)
      else $error("squaring count past s");

   // residue reduced below n before compares
   a_residue: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQ_CHECK |-> r_ff < n_ff)
      else $error("residue not reduced");

   // waiting on a product means the multiplier is running
   a_mul_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXP_MUL || state_ff == ST_EXP_SQR || state_ff == ST_SQ_WAIT)
      |-> mul_stat.busy)
      else $error("waiting on idle multiplier");

   // witness index never passes the limit
   a_wit_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WIT |-> w_ff <= WIT_LIMIT)
      else $error("witness index past limit");

endmodule

`default_nettype wire
